/* hdl/dss_pkg.sv */
// Shared definitions for the dual stack shared store: widths, codes, controller
// states and the command bundle passed from controller to datapath.
// No dependencies.
package dss_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int WORD_W        = 32;

   // Operation codes.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Stack selector codes; the other two values name no stack.
   localparam logic [1:0] SEL_LOW  = 2'd1;
   localparam logic [1:0] SEL_HIGH = 2'd2;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_NOSTACK = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_RESP = 1'b1
   } state_type;

   typedef struct packed {
      logic take;   // an input beat is accepted this cycle
   } dss_cmd_type;

endpackage

/* hdl/dss_ctrl.sv */
// Controller for the dual stack shared store: takes one beat, then holds the
// response until it is taken. Depends on dss_pkg.
module dss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output dss_pkg::dss_cmd_type cmd
);
   import dss_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_RESP:  rsp_tvalid = 1'b1;
         default: req_tready = 1'b0;
      endcase
      cmd.take = req_tvalid && req_tready;
   end

endmodule

/* hdl/dss_datapath.sv */
// Datapath for the dual stack shared store: the two stack counts, the shared
// word memory with registered read, and the response registers. Depends on dss_pkg.
module dss_datapath #(
   parameter int DEPTH = dss_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dss_pkg::dss_cmd_type         cmd,
   input  logic                         req_operation,
   input  logic [1:0]                   req_stack_select,
   input  logic signed [dss_pkg::WORD_W-1:0] req_push_value,
   output logic signed [dss_pkg::WORD_W-1:0] rsp_pop_value,
   output dss_pkg::status_type          rsp_status
);
   import dss_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] low_ff, low_in;
   logic [CW-1:0] high_ff, high_in;
   status_type    status_ff, status_in;
   logic          pop_ok_ff, pop_ok_in;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   logic [CW:0]   used_sum;
   logic          full;
   logic          wr_en, rd_en;
   logic [AW-1:0] addr;
   logic [CW-1:0] high_push_slot;
   logic [CW-1:0] high_pop_slot;
   logic [CW-1:0] low_pop_slot;

   always_comb begin
      used_sum       = {1'b0, low_ff} + {1'b0, high_ff};
      full           = used_sum >= (CW + 1)'(DEPTH);
      // The high stack grows downward from the top entry.
      high_push_slot = CW'(DEPTH - 1) - high_ff;
      high_pop_slot  = CW'(DEPTH) - high_ff;
      low_pop_slot   = low_ff - CW'(1);

      low_in    = low_ff;
      high_in   = high_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      addr      = low_ff[AW-1:0];

      if (cmd.take) begin
         pop_ok_in = 1'b0;
         if (req_operation == OP_PUSH) begin
            // Fullness is checked before the stack number.
            priority if (full) begin
               status_in = ST_FULL;
            end else if (req_stack_select == SEL_LOW) begin
               wr_en     = 1'b1;
               addr      = low_ff[AW-1:0];
               low_in    = low_ff + CW'(1);
               status_in = ST_OK;
            end else if (req_stack_select == SEL_HIGH) begin
               wr_en     = 1'b1;
               addr      = high_push_slot[AW-1:0];
               high_in   = high_ff + CW'(1);
               status_in = ST_OK;
            end else begin
               status_in = ST_NOSTACK;
            end
         end else begin
            priority if (req_stack_select == SEL_LOW) begin
               if (low_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  addr      = low_pop_slot[AW-1:0];
                  low_in    = low_pop_slot;
                  status_in = ST_OK;
                  pop_ok_in = 1'b1;
               end
            end else if (req_stack_select == SEL_HIGH) begin
               if (high_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  addr      = high_pop_slot[AW-1:0];
                  high_in   = high_ff - CW'(1);
                  status_in = ST_OK;
                  pop_ok_in = 1'b1;
               end
            end else begin
               status_in = ST_NOSTACK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      pop_ok_ff <= pop_ok_in;
   end

   // The read data is only refreshed when a pop is taken, so it holds while
   // the response waits.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= req_push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rsp_pop_value = pop_ok_ff ? $signed(rd_data_ff) : '0;
   assign rsp_status    = status_ff;

endmodule

/* hdl/dual_stack_shared_store.sv */
// Two stacks sharing one word memory: the low stack grows up from entry 0,
// the high stack grows down from the top entry.
//
// Request channel (req_): one beat is a push or a pop. tuser carries the
// operation (bit 0, 0 push, 1 pop) and the stack selector (bits 2:1, 1 low,
// 2 high); tdata carries the signed word to push.
// Response channel (rsp_): exactly one beat per request. tdata carries the
// popped word (zero unless a pop succeeded); tuser carries the status
// (0 ok, 1 store full, 2 stack empty, 3 no such stack).
// Latency: the response is valid in the cycle after the request is taken.
// Each request is handled in turn: it is taken and the memory and counts
// updated, then the response is presented; the single memory port is read or
// written at most once per request.
// A stalled response is held and no new request is taken until it goes.
// Reset clears both stack counts and returns to waiting for a request; the
// memory contents are not cleared, since a pop only reads what a push wrote.
// Depends on dss_pkg, dss_ctrl and dss_datapath.
module dual_stack_shared_store #(
   parameter int DEPTH = dss_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [dss_pkg::WORD_W-1:0]   req_tdata,   // [31:0] push_value
   input  logic [2:0]                   req_tuser,   // [0] operation, [2:1] stack_select
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [dss_pkg::WORD_W-1:0]   rsp_tdata,   // [31:0] pop_value
   output logic [1:0]                   rsp_tuser    // [1:0] status
);
   import dss_pkg::*;

   dss_cmd_type cmd;
   logic signed [WORD_W-1:0] pop_value;
   status_type  status;

   dss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dss_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_operation    (req_tuser[0]),
      .req_stack_select (req_tuser[2:1]),
      .req_push_value   ($signed(req_tdata)),
      .rsp_pop_value    (pop_value),
      .rsp_status       (status)
   );

   assign rsp_tdata = pop_value;
   assign rsp_tuser = status;

   // Only one request is in flight at a time.
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   // A taken request is answered in the next cycle.
   a_response_follows : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("response missing after a taken request");

   // Only a successful pop carries a word.
   a_zero_unless_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata == '0))
      else $error("non-zero word on a failed request");

   // A push never returns a word.
   a_push_no_word : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser[0] == OP_PUSH)) |=> (rsp_tdata == '0))
      else $error("word returned for a push");

endmodule
